// File: rtl/core/pcmunp_pkg.sv
// Shared constants, types and scaling tables of the packed PCM sample unpacker.
`timescale 1ns / 1ps

package pcmunp_pkg;

    // Full-scale positive frame value
    localparam int FRAME_FULL = 32767;

    // Sample format codes (sample_format register)
    localparam logic [2:0] FMT_U1  = 3'd0;
    localparam logic [2:0] FMT_U2  = 3'd1;
    localparam logic [2:0] FMT_U4  = 3'd2;
    localparam logic [2:0] FMT_S8  = 3'd3;
    localparam logic [2:0] FMT_U8  = 3'd4;
    localparam logic [2:0] FMT_S16 = 3'd5;

    localparam logic [2:0] FMT_RESET = FMT_S16;

    // Configuration register indexes
    localparam int          CFG_IDX_W         = 2;
    localparam int          CFG_DATA_W        = 3;
    localparam logic [1:0]  REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [1:0]  REG_SWAP_BYTES    = 2'd1;

    // Scaling tables: entry i holds i*32767/255 and i*32767/127, truncated
    typedef logic [255:0][14:0] t_lut_u8;
    typedef logic [127:0][14:0] t_lut_s7;

    function automatic t_lut_u8 build_lut_u8();
        t_lut_u8 t;
        for (int i = 0; i < 256; i++) begin
            t[i] = 15'(i * FRAME_FULL / 255);
        end
        return t;
    endfunction

    function automatic t_lut_s7 build_lut_s7();
        t_lut_s7 t;
        for (int i = 0; i < 128; i++) begin
            t[i] = 15'(i * FRAME_FULL / 127);
        end
        return t;
    endfunction

    localparam t_lut_u8 LUT_U8 = build_lut_u8();
    localparam t_lut_s7 LUT_S7 = build_lut_s7();

    // Item held in the expansion stage: format, raw byte or assembled word,
    // and the index of the next frame to emit
    typedef struct packed {
        logic [2:0]  fmt;
        logic [15:0] data;
        logic [2:0]  idx;
    } t_item;

endpackage

// File: rtl/core/pcmunp_expand.sv
// Combinational expansion of one field of the staged item into a 16-bit frame.
`timescale 1ns / 1ps

module pcmunp_expand
    import pcmunp_pkg::*;
(
    input  t_item       i_item,
    output logic [15:0] o_frame,
    output logic        o_last
);

    logic [7:0] w_byte;
    logic [7:0] w_shift;
    logic [7:0] w_rep;
    logic [7:0] w_neg;

    assign w_byte = i_item.data[7:0];
    assign w_neg  = 8'd0 - w_byte;

    // Narrow fields are MSB first; replicating a field to 8 bits scales it by
    // 255/(2^n-1), so the 8-bit unsigned table serves every unsigned width
    always_comb begin
        w_shift = 8'd0;
        w_rep   = 8'd0;
        o_frame = 16'd0;
        o_last  = 1'b1;
        unique case (i_item.fmt)
            FMT_U1: begin
                w_shift = 8'(w_byte << i_item.idx);
                w_rep   = {8{w_shift[7]}};
                o_frame = {1'b0, LUT_U8[w_rep]};
                o_last  = (i_item.idx == 3'd7);
            end
            FMT_U2: begin
                w_shift = 8'(w_byte << {i_item.idx[1:0], 1'b0});
                w_rep   = {4{w_shift[7:6]}};
                o_frame = {1'b0, LUT_U8[w_rep]};
                o_last  = (i_item.idx[1:0] == 2'd3);
            end
            FMT_U4: begin
                w_shift = 8'(w_byte << {i_item.idx[0], 2'b00});
                w_rep   = {2{w_shift[7:4]}};
                o_frame = {1'b0, LUT_U8[w_rep]};
                o_last  = i_item.idx[0];
            end
            FMT_U8: begin
                o_frame = {1'b0, LUT_U8[w_byte]};
            end
            FMT_S8: begin
                // Most negative code saturates, others scale by magnitude
                priority if (w_byte == 8'h80) begin
                    o_frame = 16'h8000;
                end else if (w_byte[7]) begin
                    o_frame = 16'd0 - {1'b0, LUT_S7[w_neg[6:0]]};
                end else begin
                    o_frame = {1'b0, LUT_S7[w_byte[6:0]]};
                end
            end
            FMT_S16: begin
                o_frame = i_item.data;
            end
            default: begin
                o_frame = 16'd0;
            end
        endcase
    end

endmodule

// File: rtl/core/packed_pcm_sample_unpacker_top.sv
// Top level of the packed PCM sample unpacker: byte intake, pair assembly,
// frame expansion stage and output register.
`timescale 1ns / 1ps

// Takes one raw byte per transfer and emits signed 16-bit frames through a
// registered output, one frame per cycle unless the sink stalls. A byte is
// taken every cycle in 8-bit and 16-bit formats unless the output stalls; a
// byte in 4-, 2- or 1-bit format holds the expansion stage until its 2, 4 or
// 8 frames have left, one per output transfer. The next byte is taken in the
// cycle the last of them leaves the stage. Frame valid follows input transfer
// through the expansion stage and the output register. In 16-bit format the
// first byte of a pair is held and the second yields the frame; a first byte
// with tlast is dropped. Formats 6 and 7 consume bytes without output.
// Configuration must only be written while no frame is outstanding.

module packed_pcm_sample_unpacker_top
    import pcmunp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // byte input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,   // end_of_buffer
    // frame output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [15:0] frame_value
    output logic                  m_axis_tlast    // last_of_run
);

    // configuration registers
    logic [2:0]  r_fmt;
    logic        r_swap;

    // pair state
    logic [7:0]  r_held;
    logic        r_half;

    // expansion stage
    logic        r_a_valid;
    t_item       r_a_item;

    // output register
    logic        r_o_valid;
    logic [15:0] r_o_frame;
    logic        r_o_last;

    logic        w_o_space;
    logic        w_a_fire;
    logic        w_a_done;
    logic        w_s_fire;
    logic        w_load;
    logic [15:0] w_frame;
    logic        w_last;
    t_item       n_a_item;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= FMT_RESET;
            r_swap <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_SAMPLE_FORMAT) begin
                r_fmt <= i_cfg_wdata;
            end
            if (i_cfg_index == REG_SWAP_BYTES) begin
                r_swap <= i_cfg_wdata[0];
            end
        end
    end

    // Handshake
    assign w_o_space     = !r_o_valid || m_axis_tready;
    assign w_a_fire      = r_a_valid && w_o_space;
    assign w_a_done      = w_a_fire && w_last;
    assign s_axis_tready = !r_a_valid || w_a_done;
    assign w_s_fire      = s_axis_tvalid && s_axis_tready;

    // Decide whether the transfer loads the expansion stage, and with what
    always_comb begin
        w_load        = 1'b0;
        n_a_item.fmt  = r_fmt;
        n_a_item.data = {8'd0, s_axis_tdata};
        n_a_item.idx  = 3'd0;
        unique case (r_fmt)
            FMT_U1, FMT_U2, FMT_U4, FMT_S8, FMT_U8: begin
                w_load = 1'b1;
            end
            FMT_S16: begin
                w_load = r_half;
                if (r_swap) begin
                    n_a_item.data = {r_held, s_axis_tdata};
                end else begin
                    n_a_item.data = {s_axis_tdata, r_held};
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // Pair state: only touched by transfers in 16-bit format
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
            r_held <= 8'd0;
        end else if (w_s_fire && r_fmt == FMT_S16) begin
            if (r_half || s_axis_tlast) begin
                r_half <= 1'b0;
            end else begin
                r_half <= 1'b1;
                r_held <= s_axis_tdata;
            end
        end
    end

    // Expansion stage: steps through the fields of the held item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_s_fire) begin
            r_a_valid <= w_load;
        end else if (w_a_done) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_a_item <= n_a_item;
        end else if (w_a_fire) begin
            r_a_item.idx <= r_a_item.idx + 3'd1;
        end
    end

    pcmunp_expand u_expand (
        .i_item  (r_a_item),
        .o_frame (w_frame),
        .o_last  (w_last)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_space) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_fire) begin
            r_o_frame <= w_frame;
            r_o_last  <= w_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_frame;
    assign m_axis_tlast  = r_o_last;

    // Checks

    // An opening byte of a pair that does not end the buffer is held
    a_pair_opens : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire && r_fmt == FMT_S16 && !r_half && !s_axis_tlast |=> r_half)
        else $error("pair did not open on first 16-bit byte");

    // A loaded item starts at its first field
    a_load_first : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire && w_load |=> r_a_valid && r_a_item.idx == 3'd0)
        else $error("expansion stage not loaded at first field");

    // A stalled expansion stage keeps its place
    a_stage_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !w_o_space |=> r_a_valid && $stable(r_a_item.idx))
        else $error("expansion stage moved while output was full");

    // Every frame from the stage is captured by the output register
    a_frame_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_a_fire |=> r_o_valid && r_o_last == $past(w_last))
        else $error("frame lost between stage and output");

endmodule

// File: tb/sv/pcm_frame_checker.sv
// Frame checker for the packed PCM sample unpacker: predicts frames per byte and compares.
`timescale 1ns / 1ps

module pcm_frame_checker
    import pcmunp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes, mirrored into shadow registers
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // byte channel
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_in_data,
    input  logic                  i_in_last,
    // frame channel
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [15:0]           i_out_data,
    input  logic                  i_out_last,
    // status for the stimulus side
    output int                    o_fail_count,
    output int                    o_frames_due,
    output int                    o_bytes_seen,
    output int                    o_frames_seen
);

    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } t_frame;

    t_frame     frame_q[$];
    t_frame     want;
    logic [2:0] fmt_shadow;
    logic       swap_shadow;
    logic [7:0] pair_first;
    logic       pair_open;
    int         fails    = 0;
    int         bytes_n  = 0;
    int         frames_n = 0;

    // Expected frames for one accepted byte under the current settings
    task automatic expand_byte(input logic [7:0] b, input logic eob);
        int          width;
        int          maxv;
        int          count;
        int          v;
        int          i;
        logic [15:0] word;
        case (fmt_shadow)
            FMT_U1, FMT_U2, FMT_U4: begin
                width = (fmt_shadow == FMT_U1) ? 1 : (fmt_shadow == FMT_U2) ? 2 : 4;
                maxv  = (1 << width) - 1;
                count = 8 / width;
                // fields leave MSB first
                for (i = 0; i < count; i++) begin
                    v = (int'(b) >> (8 - width * (i + 1))) & maxv;
                    frame_q.push_back('{value: 16'(v * FRAME_FULL / maxv),
                                        last: (i == count - 1)});
                end
            end
            FMT_S8: begin
                // -128 has no positive twin, so it pins to the negative rail
                if (b == 8'h80) v = -32768;
                else if (b[7]) v = -((256 - int'(b)) * FRAME_FULL / 127);
                else v = int'(b) * FRAME_FULL / 127;
                frame_q.push_back('{value: 16'(v), last: 1'b1});
            end
            FMT_U8: begin
                frame_q.push_back('{value: 16'(int'(b) * FRAME_FULL / 255), last: 1'b1});
            end
            FMT_S16: begin
                if (!pair_open) begin
                    // a lone first byte at the end of a buffer is dropped
                    if (!eob) begin
                        pair_first = b;
                        pair_open  = 1'b1;
                    end
                end else begin
                    pair_open = 1'b0;
                    word = swap_shadow ? {pair_first, b} : {b, pair_first};
                    frame_q.push_back('{value: word, last: 1'b1});
                end
            end
            default: begin
                // unused codes: byte consumed, nothing produced
            end
        endcase
    endtask

    // Compare frames, then predict from bytes, then track register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_shadow  = FMT_RESET;
            swap_shadow = 1'b0;
            pair_first  = 8'h00;
            pair_open   = 1'b0;
            frame_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                frames_n++;
                if (frame_q.size() == 0) begin
                    $error("frame_value %0d arrived with no frame expected",
                           $signed(i_out_data));
                    fails++;
                end else begin
                    want = frame_q.pop_front();
                    if (i_out_data !== want.value) begin
                        $error("frame_value: expected %0d, actual %0d",
                               $signed(want.value), $signed(i_out_data));
                        fails++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last, i_out_last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                bytes_n++;
                expand_byte(i_in_data, i_in_last);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SAMPLE_FORMAT) fmt_shadow = i_cfg_wdata;
                else if (i_cfg_index == REG_SWAP_BYTES) swap_shadow = i_cfg_wdata[0];
            end
        end
        o_fail_count  <= fails;
        o_frames_due  <= frame_q.size();
        o_bytes_seen  <= bytes_n;
        o_frames_seen <= frames_n;
    end

endmodule

// File: tb/sv/tb_packed_pcm_sample_unpacker_top.sv
// Testbench top for the packed PCM sample unpacker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_packed_pcm_sample_unpacker_top;
    import pcmunp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 16;

    // codes with no meaning in the block, used to check they are ignored
    localparam logic [2:0]           FMT_NONE_6  = 3'd6;
    localparam logic [2:0]           FMT_NONE_7  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [7:0]            s_axis_tdata  = 8'h00;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tready = 1'b0;
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire  [15:0]           m_axis_tdata;
    wire                   m_axis_tlast;

    int fail_count;
    int frames_due;
    int bytes_seen;
    int frames_seen;
    int cycle_count = 0;
    int stall_left  = 0;
    bit sink_calm   = 1'b0;
    bit source_calm = 1'b0;

    packed_pcm_sample_unpacker_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    pcm_frame_checker frame_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_last     (s_axis_tlast),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_last    (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_frames_due  (frames_due),
        .o_bytes_seen  (bytes_seen),
        .o_frames_seen (frames_seen)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 2);
        return $urandom_range(8, 40);
    endfunction

    // Byte value with a bias toward the edges of the range
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 7) != 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h80;
            3:       return 8'h7f;
            4:       return 8'h01;
            default: return 8'h81;
        endcase
    endfunction

    // Frame sink back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // One byte transfer; valid stays high when the next byte follows at once
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eob;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (!source_calm && $urandom_range(0, 1) == 1) begin
            gap = pick_gap() + 1;
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the source until every predicted frame is out and the pipe is empty
    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (frames_due != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [2:0] fmt, input logic swap);
        drain_frames();
        write_reg(REG_SAMPLE_FORMAT, fmt);
        write_reg(REG_SWAP_BYTES, {2'b00, swap});
    endtask

    // Run-length watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("Some tests failed");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        logic [2:0] fmt;
        logic       eob;
        int         len;
        int         budget;
        int         sent;
        int         j;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 16-bit native order straight out of reset
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h5a, 1'b1);   // odd trailing byte, dropped
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b1);

        // swapped order, then a pair split by a detour through 8-bit unsigned
        set_mode(FMT_S16, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hab, 1'b0);
        set_mode(FMT_U8, 1'b1);
        send_byte(8'hff, 1'b0);
        set_mode(FMT_S16, 1'b1);
        send_byte(8'hcd, 1'b1);

        // narrow unsigned fields
        set_mode(FMT_U1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'ha5, 1'b1);
        set_mode(FMT_U2, 1'b0);
        send_byte(8'h1b, 1'b0);
        set_mode(FMT_U4, 1'b0);
        send_byte(8'hf0, 1'b1);

        // signed byte including the saturating minimum
        set_mode(FMT_S8, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);

        // unsigned byte; writes to unmapped indexes and upper swap bits change nothing
        set_mode(FMT_U8, 1'b1);
        write_reg(REG_SPARE_2, 3'd7);
        write_reg(REG_SPARE_3, 3'd1);
        write_reg(REG_SWAP_BYTES, 3'b110);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);

        // unused format codes swallow bytes
        set_mode(FMT_NONE_6, 1'b0);
        send_byte(8'h3c, 1'b0);
        set_mode(FMT_NONE_7, 1'b1);
        send_byte(8'hc3, 1'b1);

        // random buffers, one setting per phase
        for (int ph = 0; ph < 12; ph++) begin
            fmt = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 5));
            set_mode(fmt, 1'($urandom_range(0, 1)));
            source_calm = (ph % 4 == 3);
            sink_calm   = (ph % 4 == 1);
            budget = (fmt > FMT_S16) ? 6 : 30;
            sent   = 0;
            while (sent < budget) begin
                len = $urandom_range(1, 12);
                for (j = 0; j < len; j++) begin
                    eob = (j == len - 1);
                    // occasional stray end marker or a missing one
                    if ($urandom_range(0, 19) == 0) eob = 1'($urandom_range(0, 1));
                    send_byte(pick_byte(), eob);
                    sent++;
                end
                if ($urandom_range(0, 9) == 0) drain_frames();
            end
        end
        source_calm = 1'b0;
        sink_calm   = 1'b0;

        drain_frames();
        $display("Checked %0d frames from %0d bytes across every sample format,",
                 frames_seen, bytes_seen);
        $display("both byte orders, odd trailing bytes, split pairs and unused codes.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: packed_pcm_sample_unpacker_top.f
rtl/core/pcmunp_pkg.sv
rtl/core/pcmunp_expand.sv
rtl/core/packed_pcm_sample_unpacker_top.sv
tb/sv/pcm_frame_checker.sv
tb/sv/tb_packed_pcm_sample_unpacker_top.sv
